// ----- hdl/u8dw_pkg.sv -----
package u8dw_pkg;

  // running total width inside the block and on the output
  localparam int unsigned TOTAL_WIDTH_BITS = 16;
  localparam int unsigned OUT_TOTAL_BITS   = 16;

  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] MIN_LEN2  = 21'h000080;
  localparam logic [20:0] MIN_LEN3  = 21'h000800;
  localparam logic [20:0] MIN_LEN4  = 21'h010000;
  localparam logic [20:0] ZWJ       = 21'h00200D;

  localparam logic [2:0] LEN_STRAY = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  typedef logic [3:0][7:0] byte_buf_t;

  // outcome of decoding at one scan position
  typedef struct packed {
    logic        hold;
    logic [20:0] cp;
    logic        raw;
    logic [2:0]  adv;
  } scan_step_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                   len = LEN_ONE;
    else if (b[7:5] == 3'b110)   len = LEN_TWO;
    else if (b[7:4] == 4'b1110)  len = LEN_THREE;
    else if (b[7:3] == 5'b11110) len = LEN_FOUR;
    else                         len = LEN_STRAY;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic in_range(input logic [20:0] c, input logic [20:0] lo,
                                    input logic [20:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // display columns of one code point
  function automatic logic [1:0] cols_of(input logic [20:0] c);
    logic zero_w;
    logic wide;
    zero_w = (c < 21'h20) || in_range(c, 21'h7F, 21'h9F) ||
             in_range(c, 21'h0300, 21'h036F) || in_range(c, 21'h1AB0, 21'h1AFF) ||
             in_range(c, 21'h1DC0, 21'h1DFF) || in_range(c, 21'h20D0, 21'h20FF) ||
             in_range(c, 21'hFE00, 21'hFE0F) || in_range(c, 21'hFE20, 21'hFE2F) ||
             (c == ZWJ);
    wide = (c == 21'h3000) || in_range(c, 21'h1100, 21'h115F) ||
           in_range(c, 21'h2329, 21'h232A) || in_range(c, 21'h2E80, 21'hA4CF) ||
           in_range(c, 21'hAC00, 21'hD7A3) || in_range(c, 21'hF900, 21'hFAFF) ||
           in_range(c, 21'hFE10, 21'hFE19) || in_range(c, 21'hFE30, 21'hFE6F) ||
           in_range(c, 21'hFF00, 21'hFF60) || in_range(c, 21'hFFE0, 21'hFFE6) ||
           in_range(c, 21'h1F000, 21'h1FAFF) || in_range(c, 21'h2600, 21'h27BF) ||
           in_range(c, 21'h20000, 21'h3FFFD);
    if (zero_w)    return 2'd0;
    else if (wide) return 2'd2;
    else           return 2'd1;
  endfunction

  // decode one sequence starting at position p of the byte buffer
  function automatic scan_step_t scan_at(input byte_buf_t bytes, input logic [2:0] n,
                                         input logic [1:0] p, input logic last);
    scan_step_t  res;
    logic [7:0]  lead;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] mn;
    logic [1:0]  idx;
    lead      = bytes[p];
    len       = lead_len(lead);
    avail     = n - {1'b0, p};
    res.hold  = 1'b0;
    res.cp    = {13'd0, lead};
    res.raw   = 1'b1;
    res.adv   = 3'd1;
    bad       = 1'b0;
    cp        = '0;
    mn        = '0;
    for (int k = 1; k < 4; k++) begin
      idx = p + 2'(k);
      if ((3'(k) < avail) && (3'(k) < len) && !is_cont(bytes[idx])) bad = 1'b1;
    end
    if (len <= LEN_ONE) begin
      res.raw = lead[7];
    end else if (bad || ((avail < len) && last)) begin
      res.raw = 1'b1;
    end else if (avail < len) begin
      res.hold = 1'b1;
    end else begin
      case (len)
        LEN_TWO: begin
          cp = {10'd0, lead[4:0], bytes[p + 2'd1][5:0]};
          mn = MIN_LEN2;
        end
        LEN_THREE: begin
          cp = {5'd0, lead[3:0], bytes[p + 2'd1][5:0], bytes[p + 2'd2][5:0]};
          mn = MIN_LEN3;
        end
        default: begin
          cp = {lead[2:0], bytes[p + 2'd1][5:0], bytes[p + 2'd2][5:0],
                bytes[p + 2'd3][5:0]};
          mn = MIN_LEN4;
        end
      endcase
      if (!((cp < mn) || in_range(cp, SURR_LO, SURR_HI) || (cp > CP_MAX))) begin
        res.cp  = cp;
        res.raw = 1'b0;
        res.adv = len;
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/u8dw_in_if.sv -----
interface u8dw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       text_last;

  modport source (output valid, output data_byte, output text_last, input ready);
  modport sink   (input valid, input data_byte, input text_last, output ready);
endinterface

// ----- hdl/u8dw_out_if.sv -----
interface u8dw_out_if
  import u8dw_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [20:0]               char_code;
  logic [1:0]                char_width;
  logic                      raw_fallback;
  logic [OUT_TOTAL_BITS-1:0] total_width;
  logic                      run_last;
  logic                      text_end;

  modport source (output valid, output char_code, output char_width, output raw_fallback,
                  output total_width, output run_last, output text_end, input ready);
  modport sink   (input valid, input char_code, input char_width, input raw_fallback,
                  input total_width, input run_last, input text_end, output ready);
endinterface

// ----- hdl/utf8_display_width.sv -----
// Streaming UTF-8 decoder with a display-width tally. One byte is taken per input
// transfer; each byte yields zero to four code points on the output, each with its
// column width (0, 1 or 2) and the running total, which saturates at 65535 and
// restarts after the byte flagged text_last. Invalid, overlong, surrogate,
// out-of-range and truncated sequences send the lead byte out raw with raw_fallback
// set, and the bytes after it are scanned again. A byte is taken in only while the
// block is idle; it then gives out one code point per cycle while the output slot
// is free, and returns to idle with its last result, or without a result if the
// byte only joins a pending sequence. Two decoders look at the current and the next
// scan position; the output register lets the next byte come in while a result waits.
module utf8_display_width
  import u8dw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  u8dw_in_if.sink    in_i,
  u8dw_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                        state_q, state_d;
  byte_buf_t                   buf_q, buf_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic [2:0]                  n_q, n_d;
  logic [1:0]                  pos_q, pos_d;
  logic                        last_q, last_d;
  logic [TOTAL_WIDTH_BITS-1:0] sum_q, sum_d;

  logic                        out_valid_q;
  logic [20:0]                 cp_q;
  logic [1:0]                  width_q;
  logic                        raw_q;
  logic [TOTAL_WIDTH_BITS-1:0] total_q;
  logic                        run_last_q;
  logic                        text_end_q;

  scan_step_t                  cur;
  scan_step_t                  nxt;
  logic [2:0]                  newpos;
  logic                        slot_free;
  logic                        emit;
  logic                        final_emit;
  logic                        fin;
  logic [2:0]                  base;
  logic [2:0]                  rem;
  logic [1:0]                  w;
  logic [TOTAL_WIDTH_BITS:0]   sum_ext;
  logic [TOTAL_WIDTH_BITS-1:0] sum_sat;

  assign in_i.ready = (state_q == ST_IDLE);

  // decode unit at the current position, plus a second one at the next position
  assign cur    = scan_at(buf_q, n_q, pos_q, last_q);
  assign newpos = {1'b0, pos_q} + cur.adv;
  assign nxt    = scan_at(buf_q, n_q, newpos[1:0], last_q);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign emit       = (state_q == ST_SCAN) && !cur.hold && slot_free;
  assign final_emit = (newpos >= n_q) || nxt.hold;
  assign fin        = (state_q == ST_SCAN) && (cur.hold || (emit && final_emit));
  assign base       = cur.hold ? {1'b0, pos_q} : newpos;
  assign rem        = n_q - base;

  // saturating width accumulation
  assign w       = cols_of(cur.cp);
  assign sum_ext = {1'b0, sum_q} + (TOTAL_WIDTH_BITS + 1)'(w);
  assign sum_sat = sum_ext[TOTAL_WIDTH_BITS] ? '1 : sum_ext[TOTAL_WIDTH_BITS-1:0];

  // sequencer next state
  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    pos_d   = pos_q;
    last_d  = last_q;
    sum_d   = sum_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          buf_d[cnt_q] = in_i.data_byte;
          n_d          = {1'b0, cnt_q} + 3'd1;
          pos_d        = '0;
          last_d       = in_i.text_last;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (emit) begin
          sum_d = sum_sat;
          pos_d = newpos[1:0];
        end
        if (fin) begin
          // keep the unfinished prefix at the front of the buffer
          for (int k = 0; k < 3; k++) begin
            buf_d[k] = buf_q[2'(base + 3'(k))];
          end
          cnt_d   = last_q ? 2'd0 : rem[1:0];
          state_d = ST_IDLE;
          if (last_q) sum_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
      sum_q   <= sum_d;
    end
  end

  // byte buffer
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cp_q       <= cur.cp;
      width_q    <= w;
      raw_q      <= cur.raw;
      total_q    <= sum_sat;
      run_last_q <= final_emit;
      text_end_q <= final_emit && last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.char_code    = cp_q;
  assign out_o.char_width   = width_q;
  assign out_o.raw_fallback = raw_q;
  assign out_o.total_width  = OUT_TOTAL_BITS'(total_q);
  assign out_o.run_last     = run_last_q;
  assign out_o.text_end     = text_end_q;

  // the end of a text is always the last result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && text_end_q) |-> run_last_q)
    else $error("text_end without run_last");

  // a raw result carries a single byte, a decoded one stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((raw_q && cp_q < 21'h100) || (!raw_q && cp_q <= CP_MAX)))
    else $error("result code point out of range");

  // held bytes are always an incomplete prefix of a multibyte sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cnt_q != 2'd0) |->
      (lead_len(buf_q[0]) > {1'b0, cnt_q} && lead_len(buf_q[0]) != LEN_STRAY))
    else $error("held bytes are not a pending sequence");

  // the end of a text clears the tally and the held bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && last_q) |=> (sum_q == '0 && cnt_q == 2'd0))
    else $error("state not cleared after text end");

  // a byte flagged as the end of a text never finishes without a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last_q) |-> !cur.hold)
    else $error("bytes held at text end");

endmodule

// ----- tb/utf8_display_width_test.sv -----
module utf8_display_width_test;
  import u8dw_pkg::*;

  localparam longint unsigned COLUMN_CAP = (64'd1 << TOTAL_WIDTH_BITS) - 64'd1;
  localparam int DIRECTED_ROWS = 26;
  localparam int EDGE_COUNT = 46;
  localparam int PHASE_COUNT = 4;
  localparam int PHASE_BYTES = 110;
  localparam int LAST_PCT = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  // one decoded code point as it leaves the block
  typedef struct packed {
    logic [20:0]               cp;
    logic [1:0]                cols;
    logic                      raw;
    logic [OUT_TOTAL_BITS-1:0] total;
    logic                      run_last;
    logic                      text_end;
  } glyph_t;

  // directed text byte, with the first result typed in where it is obvious
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [2:0]  count;
    logic [20:0] cp;
    logic [1:0]  cols;
    logic        raw;
  } text_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u8dw_in_if  in_bus ();
  u8dw_out_if out_bus ();

  utf8_display_width i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // decoder copy: bytes of an unfinished sequence and the running column total
  logic [7:0]      held_bytes [3];
  int              held_count = 0;
  longint unsigned col_total = 0;
  glyph_t          fresh_glyphs [4];
  int              fresh_count;
  glyph_t          expected_glyphs [$];
  logic [7:0]      byte_backlog [$];
  int              failure_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;

  int send_idle_plan [PHASE_COUNT] = '{0, 87, 0, 27};
  int recv_stall_plan [PHASE_COUNT] = '{0, 0, 87, 27};

  // code points at every width boundary; the random text adds an offset of -1 to +1
  int unsigned width_edges [EDGE_COUNT] = '{
    'h1F, 'h20, 'h7E, 'h7F, 'h9F, 'hA0, 'h2FF, 'h300, 'h36F, 'h1100, 'h115F, 'h1AB0,
    'h1AFF, 'h1DC0, 'h1DFF, 'h200D, 'h20D0, 'h20FF, 'h2329, 'h232A, 'h2600, 'h27BF,
    'h2E80, 'h3000, 'hA4CF, 'hAC00, 'hD7A3, 'hF900, 'hFAFF, 'hFE00, 'hFE0F, 'hFE10,
    'hFE19, 'hFE20, 'hFE2F, 'hFE30, 'hFE6F, 'hFF00, 'hFF60, 'hFFE0, 'hFFE6, 'h1F000,
    'h1FAFF, 'h20000, 'h3FFFD, 'h10FFFF
  };

  text_row_t directed_text [DIRECTED_ROWS] = '{
    // control, stray lead, stray continuation
    '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 2'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 3'd1, 21'h0000FF, 2'd1, 1'b1},
    '{8'h80, 1'b0, 1'b1, 3'd1, 21'h000080, 2'd0, 1'b1},
    // combining mark, two bytes
    '{8'hCC, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h81, 1'b0, 1'b1, 3'd1, 21'h000301, 2'd0, 1'b0},
    // wide emoji, four bytes
    '{8'hF0, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h9F, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h98, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd1, 21'h01F600, 2'd2, 1'b0},
    // overlong form
    '{8'hC0, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd2, 21'h0000C0, 2'd1, 1'b1},
    // surrogate
    '{8'hED, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'hA0, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd3, 21'h0000ED, 2'd1, 1'b1},
    // above the code point range
    '{8'hF4, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd4, 21'h0000F4, 2'd1, 1'b1},
    // sequence broken by an ascii byte
    '{8'hE2, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h41, 1'b0, 1'b1, 3'd2, 21'h0000E2, 2'd1, 1'b1},
    // largest code point
    '{8'hF4, 1'b0, 1'b0, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 3'd1, 21'h10FFFF, 2'd1, 1'b0},
    // text cut short inside a sequence
    '{8'hE4, 1'b0, 1'b1, 3'd0, 21'h000000, 2'd0, 1'b0},
    '{8'hB8, 1'b1, 1'b1, 3'd2, 21'h0000E4, 2'd1, 1'b1}
  };

  function automatic void flag_mismatch(input string msg);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // display columns: zero for controls and combining marks, two for wide ranges
  function automatic logic [1:0] columns_of(input logic [20:0] c);
    if (c < 21'h20 || c inside {[21'h7F:21'h9F], [21'h300:21'h36F], [21'h1AB0:21'h1AFF],
        [21'h1DC0:21'h1DFF], [21'h20D0:21'h20FF], [21'hFE00:21'hFE0F],
        [21'hFE20:21'hFE2F], 21'h200D})
      return 2'd0;
    if (c inside {21'h3000, [21'h1100:21'h115F], [21'h2329:21'h232A],
        [21'h2E80:21'hA4CF], [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF],
        [21'hFE10:21'hFE19], [21'hFE30:21'hFE6F], [21'hFF00:21'hFF60],
        [21'hFFE0:21'hFFE6], [21'h1F000:21'h1FAFF], [21'h2600:21'h27BF],
        [21'h20000:21'h3FFFD]})
      return 2'd2;
    return 2'd1;
  endfunction

  // full sequence length from a lead byte, zero for a byte that cannot lead
  function automatic int seq_length(input logic [7:0] b);
    if (!b[7])                   return 1;
    if (b[7:5] == 3'b110)        return 2;
    if (b[7:4] == 4'b1110)       return 3;
    if (b[7:3] == 5'b11110)      return 4;
    return 0;
  endfunction

  // add one code point to the running total, saturating
  function automatic void add_glyph(input logic [20:0] c, input logic raw);
    logic [1:0] w;
    if (fresh_count >= 4) return;
    w = columns_of(c);
    if (col_total > COLUMN_CAP - w) col_total = COLUMN_CAP;
    else col_total += w;
    fresh_glyphs[fresh_count] = '{c, w, raw, col_total[OUT_TOTAL_BITS-1:0], 1'b0, 1'b0};
    fresh_count++;
  endfunction

  // decode the held bytes plus one new byte and queue the code points it yields
  function automatic int decode_and_tally(input logic [7:0] b, input logic last,
                                          output glyph_t first);
    logic [7:0]  scan [4];
    int          n;
    int          pos;
    int          len;
    int          avail;
    logic        broken;
    logic        waiting;
    int unsigned cp;
    int unsigned floor_cp;
    n = held_count;
    for (int k = 0; k < n; k++) scan[k] = held_bytes[k];
    scan[n] = b;
    n++;
    pos = 0;
    waiting = 1'b0;
    fresh_count = 0;
    while (pos < n && !waiting) begin
      len = seq_length(scan[pos]);
      avail = n - pos;
      broken = 1'b0;
      for (int k = 1; k < avail && k < len; k++) begin
        if (scan[pos + k][7:6] != 2'b10) broken = 1'b1;
      end
      if (len <= 1) begin
        add_glyph({13'd0, scan[pos]}, scan[pos][7]);
        pos++;
      end else if (broken || (avail < len && last)) begin
        add_glyph({13'd0, scan[pos]}, 1'b1);
        pos++;
      end else if (avail < len) begin
        waiting = 1'b1;
      end else begin
        // lead keeps 7 - len payload bits, each continuation six
        cp = scan[pos] & (8'hFF >> (len + 1));
        for (int k = 1; k < len; k++) cp = (cp << 6) | scan[pos + k][5:0];
        floor_cp = (len == 2) ? 'h80 : (len == 3) ? 'h800 : 'h10000;
        if (cp < floor_cp || (cp >= 'hD800 && cp <= 'hDFFF) || cp > 'h10FFFF) begin
          add_glyph({13'd0, scan[pos]}, 1'b1);
          pos++;
        end else begin
          add_glyph(cp[20:0], 1'b0);
          pos += len;
        end
      end
    end
    held_count = n - pos;
    for (int k = 0; k < held_count; k++) held_bytes[k] = scan[pos + k];
    if (fresh_count > 0) begin
      fresh_glyphs[fresh_count - 1].run_last = 1'b1;
      fresh_glyphs[fresh_count - 1].text_end = last;
    end
    for (int k = 0; k < fresh_count; k++) expected_glyphs = {expected_glyphs, fresh_glyphs[k]};
    first = fresh_glyphs[0];
    if (last) begin
      col_total = 0;
      held_count = 0;
    end
    return fresh_count;
  endfunction

  // add one byte at the end of the stimulus backlog
  function automatic void stash_byte(input logic [7:0] b);
    byte_backlog = {byte_backlog, b};
  endfunction

  // utf-8 encoding at a chosen length, which may be overlong or out of range
  function automatic void append_utf8(input int unsigned cp, input int len);
    case (len)
      1: stash_byte(8'(cp));
      2: begin
        stash_byte(8'hC0 | 8'((cp >> 6) & 'h1F));
        stash_byte(8'h80 | 8'(cp & 'h3F));
      end
      3: begin
        stash_byte(8'hE0 | 8'((cp >> 12) & 'h0F));
        stash_byte(8'h80 | 8'((cp >> 6) & 'h3F));
        stash_byte(8'h80 | 8'(cp & 'h3F));
      end
      default: begin
        stash_byte(8'hF0 | 8'((cp >> 18) & 'h07));
        stash_byte(8'h80 | 8'((cp >> 12) & 'h3F));
        stash_byte(8'h80 | 8'((cp >> 6) & 'h3F));
        stash_byte(8'h80 | 8'(cp & 'h3F));
      end
    endcase
  endfunction

  // legal code point that needs exactly len bytes
  function automatic int unsigned random_point(input int len);
    int unsigned cp;
    case (len)
      2: cp = $urandom_range('h7FF, 'h80);
      3: begin
        cp = $urandom_range('hFFFF, 'h800);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp ^= 'h2000;
      end
      default: cp = $urandom_range(1) ? $urandom_range('h3FFFD, 'h1F000)
                                      : $urandom_range('h10FFFF, 'h10000);
    endcase
    return cp;
  endfunction

  // mostly well-formed characters, the rest bad forms and noise
  function automatic void queue_random_text();
    int          pick;
    int          len;
    int unsigned cp;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 25) begin
      append_utf8($urandom_range('h7F), 1);
    end else if (pick < 60) begin
      len = $urandom_range(4, 2);
      append_utf8(random_point(len), len);
    end else if (pick < 74) begin
      cp = width_edges[$urandom_range(EDGE_COUNT - 1)] + $urandom_range(2) - 1;
      len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
      append_utf8(cp, len);
    end else if (pick < 79) begin
      // overlong
      len = $urandom_range(4, 2);
      append_utf8($urandom_range((len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF), len);
    end else if (pick < 83) begin
      append_utf8($urandom_range('hDFFF, 'hD800), 3);
    end else if (pick < 87) begin
      append_utf8($urandom_range('h1FFFFF, 'h110000), 4);
    end else if (pick < 96) begin
      // prefix of a sequence, sometimes cut by a byte that is no continuation
      len = $urandom_range(4, 2);
      append_utf8(random_point(len), len);
      repeat ($urandom_range(len - 1, 1)) void'(byte_backlog.pop_back());
      if (pick >= 91) begin
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        stash_byte(b);
      end
    end else begin
      stash_byte(8'($urandom_range(255)));
    end
  endfunction

  // one input transfer; called and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic last, output int made,
                           output glyph_t first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.text_last <= last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    made = decode_and_tally(b, last, first);
    @(negedge clk_i);
  endtask

  task automatic send_next_byte(input int last_pct);
    logic [7:0] b;
    int         made;
    glyph_t     first;
    b = byte_backlog.pop_front();
    push_byte(b, $urandom_range(99) < last_pct, made, first);
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each output transfer with the oldest expected code point
  always @(posedge clk_i) begin : check_output
    glyph_t seen;
    glyph_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      seen = '{out_bus.char_code, out_bus.char_width, out_bus.raw_fallback,
               out_bus.total_width, out_bus.run_last, out_bus.text_end};
      if (expected_glyphs.size() == 0) begin
        flag_mismatch($sformatf("unexpected output (expected none): cp %h width %0d",
                                seen.cp, seen.cols));
      end else begin
        want = expected_glyphs.pop_front();
        if (seen !== want)
          flag_mismatch($sformatf({"mismatch (expected/actual): cp %h/%h width %0d/%0d ",
                                   "raw %0b/%0b total %0d/%0d run_last %0b/%0b end %0b/%0b"},
                                  want.cp, seen.cp, want.cols, seen.cols, want.raw, seen.raw,
                                  want.total, seen.total, want.run_last, seen.run_last,
                                  want.text_end, seen.text_end));
      end
    end
  end

  initial begin
    int     made;
    glyph_t first;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.text_last = 1'b0;
    rst_ni           = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed text: extremes, every bad form, truncation
    foreach (directed_text[i]) begin
      push_byte(directed_text[i].data, directed_text[i].last, made, first);
      if (directed_text[i].typed && (made != directed_text[i].count || (made > 0 &&
          (first.cp !== directed_text[i].cp || first.cols !== directed_text[i].cols ||
           first.raw !== directed_text[i].raw))))
        flag_mismatch($sformatf({"directed byte %0d (expected/actual): results %0d/%0d ",
                                 "cp %h/%h width %0d/%0d raw %0b/%0b"},
                                i, directed_text[i].count, made, directed_text[i].cp,
                                first.cp, directed_text[i].cols, first.cols,
                                directed_text[i].raw, first.raw));
    end

    // random text under each idling pattern
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct  = send_idle_plan[phase];
      recv_stall_pct = recv_stall_plan[phase];
      for (int k = 0; k < PHASE_BYTES; k++) begin
        if (byte_backlog.size() == 0) queue_random_text();
        send_next_byte(LAST_PCT);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // end the text, then the total must start over
    push_byte(8'h41, 1'b1, made, first);
    push_byte(8'h41, 1'b0, made, first);
    push_byte(8'h42, 1'b1, made, first);
    in_bus.valid <= 1'b0;

    while (expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/u8dw_pkg.sv
hdl/u8dw_in_if.sv
hdl/u8dw_out_if.sv
hdl/utf8_display_width.sv
tb/utf8_display_width_test.sv
